// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps
package tcs_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;
    localparam int TIME_W    = 32;
    localparam int QUANTUM_W = 16;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_PSJF = 2'd3;

    localparam logic [1:0] REG_POLICY  = 2'd0;
    localparam logic [1:0] REG_NPROCS  = 2'd1;
    localparam logic [1:0] REG_QUANTUM = 2'd2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_ARRIVE,
        ST_PURGE,
        ST_SCAN,
        ST_COMMIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic retire;
        logic arrive_first;
        logic arrive_step;
        logic purge_step;
        logic scan_first;
        logic scan_step;
        logic commit;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic last_slot;
        logic purge_done;
    } stat_t;
endpackage

// ===== rtl/tcs_if.sv =====
`timescale 1ns / 1ps
interface tcs_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  slot;
    logic [31:0] arrival;
    logic [31:0] burst;
    modport source (output valid, func, slot, arrival, burst, input ready);
    modport sink   (input valid, func, slot, arrival, burst, output ready);
endinterface

interface tcs_out_if;
    logic        valid;
    logic        ready;
    logic        cpu_busy;
    logic [3:0]  running_slot;
    logic        finished_valid;
    logic [3:0]  finished_slot;
    logic        all_done;
    logic [31:0] tick_time;
    modport source (output valid, cpu_busy, running_slot, finished_valid, finished_slot,
                    all_done, tick_time, input ready);
    modport sink   (input valid, cpu_busy, running_slot, finished_valid, finished_slot,
                    all_done, tick_time, output ready);
endinterface

// ===== rtl/tcs_ctrl.sv =====
`timescale 1ns / 1ps
module tcs_ctrl
    import tcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_func,
    input  logic  out_free,
    input  stat_t stat,
    output logic  in_ready,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid && in_func == FUNC_TICK)
                    state_next = ST_RETIRE;
            ST_RETIRE: state_next = ST_ARRIVE;
            ST_ARRIVE:
                if (stat.done)
                    state_next = ST_OUT;
                else if (stat.last_slot)
                    state_next = ST_PURGE;
            ST_PURGE:
                if (stat.purge_done)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (stat.last_slot)
                    state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && in_func == FUNC_LOAD;
            end
            ST_RETIRE:
            begin
                cmd.retire = 1'b1;
                cmd.arrive_first = 1'b1;
            end
            ST_ARRIVE:
            begin
                cmd.arrive_step = !stat.done;
                cmd.scan_first = stat.last_slot;
            end
            ST_PURGE: cmd.purge_step = !stat.purge_done;
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_COMMIT: cmd.commit = 1'b1;
            ST_OUT:    cmd.capture = out_free;
            default:   cmd = '0;
        endcase
    end
endmodule

// ===== rtl/tcs_dp.sv =====
`timescale 1ns / 1ps
module tcs_dp
    import tcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [SLOT_W-1:0]    in_slot,
    input  logic [TIME_W-1:0]    in_arrival,
    input  logic [TIME_W-1:0]    in_burst,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_idx,
    input  logic [QUANTUM_W-1:0] cfg_data,
    output stat_t                stat,
    output logic                 res_busy,
    output logic [SLOT_W-1:0]    res_run,
    output logic                 res_fin,
    output logic [SLOT_W-1:0]    res_fin_slot,
    output logic                 res_done,
    output logic [TIME_W-1:0]    res_time
);
    logic [TIME_W-1:0] arr_mem [SLOTS];
    logic [TIME_W-1:0] rem_mem [SLOTS];
    logic [SLOT_W-1:0] ring_mem [SLOTS];

    logic [1:0]           policy_reg;
    logic [CNT_W-1:0]     nprocs_reg;
    logic [QUANTUM_W-1:0] quantum_reg;
    logic [SLOTS-1:0]     ready_reg;
    logic [SLOT_W-1:0]    head_reg, runner_reg, idx_reg, best_reg;
    logic [CNT_W-1:0]     count_reg, retired_reg;
    logic                 run_v_reg, done_reg, fin_reg, have_reg;
    logic [SLOT_W-1:0]    fin_slot_reg;
    logic                 busy_reg;
    logic [SLOT_W-1:0]    run_reg;
    logic [QUANTUM_W-1:0] slice_reg;
    logic [TIME_W-1:0]    now_reg, best_rem_reg, t_reg;

    logic [CNT_W-1:0]     n_eff;
    logic [QUANTUM_W-1:0] q_eff;
    logic [SLOT_W-1:0]    front, tail_pos;
    logic                 front_ok, rr_rot, is_rr, is_sjf, pick_v, switch;
    logic [SLOT_W-1:0]    pick;
    logic                 rr_clear_slice;
    logic                 retire_now;

    always_comb
    begin
        if (nprocs_reg == '0)
            n_eff = CNT_W'(1);
        else if (nprocs_reg > CNT_W'(SLOTS))
            n_eff = CNT_W'(SLOTS);
        else
            n_eff = nprocs_reg;
        q_eff = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    end

    assign is_rr  = policy_reg == POL_RR;
    assign is_sjf = policy_reg == POL_SJF || policy_reg == POL_PSJF;
    assign front  = ring_mem[head_reg];
    assign front_ok = {1'b0, front} < n_eff && ready_reg[front]
                      && !(run_v_reg && front == runner_reg);
    assign tail_pos = head_reg + count_reg[SLOT_W-1:0];
    assign rr_rot = slice_reg >= q_eff;
    assign retire_now = !done_reg && run_v_reg && rem_mem[runner_reg] == '0;

    assign stat.done       = done_reg;
    assign stat.last_slot  = {1'b0, idx_reg} == n_eff - CNT_W'(1);
    assign stat.purge_done = !is_rr || count_reg == '0 || front_ok;

    // pick for the commit step
    always_comb
    begin
        pick = runner_reg;
        pick_v = run_v_reg;
        rr_clear_slice = 1'b0;
        case (policy_reg)
            POL_FIFO, POL_SJF:
                if (!run_v_reg)
                begin
                    pick = best_reg;
                    pick_v = have_reg;
                end
            POL_PSJF:
            begin
                pick = best_reg;
                pick_v = have_reg;
            end
            POL_RR:
                if (count_reg == '0)
                    rr_clear_slice = rr_rot;
                else if (!run_v_reg || rr_rot)
                begin
                    pick = front;
                    pick_v = 1'b1;
                end
            default: pick = runner_reg;
        endcase
    end
    assign switch = pick_v && !(run_v_reg && pick == runner_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            arr_mem[in_slot] <= in_arrival;
            rem_mem[in_slot] <= in_burst;
        end
        else if (cmd.commit && (switch ? 1'b1 : run_v_reg))
        begin
            if (rem_mem[switch ? pick : runner_reg] != '0)
                rem_mem[switch ? pick : runner_reg] <=
                    rem_mem[switch ? pick : runner_reg] - TIME_W'(1);
        end
        if (cmd.arrive_step && is_rr && arr_mem[idx_reg] == now_reg
            && count_reg < CNT_W'(SLOTS))
            ring_mem[tail_pos] <= idx_reg;
        else if (cmd.commit && is_rr && switch && run_v_reg)
            // preempted runner to tail, after the pop
            ring_mem[tail_pos] <= runner_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= POL_FIFO;
            nprocs_reg  <= CNT_W'(SLOTS);
            quantum_reg <= QUANTUM_W'(500);
            ready_reg   <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            runner_reg  <= '0;
            run_v_reg   <= 1'b0;
            slice_reg   <= '0;
            now_reg     <= '0;
            retired_reg <= '0;
            done_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            fin_slot_reg <= '0;
            busy_reg    <= 1'b0;
            run_reg     <= '0;
            idx_reg     <= '0;
            best_reg    <= '0;
            best_rem_reg <= '0;
            have_reg    <= 1'b0;
            t_reg       <= '0;
            res_busy    <= 1'b0;
            res_run     <= '0;
            res_fin     <= 1'b0;
            res_fin_slot <= '0;
            res_done    <= 1'b0;
            res_time    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_POLICY:  policy_reg  <= cfg_data[1:0];
                    REG_NPROCS:  nprocs_reg  <= cfg_data[CNT_W-1:0];
                    REG_QUANTUM: quantum_reg <= cfg_data;
                    default:     policy_reg  <= policy_reg;
                endcase
            end
            if (cmd.retire)
            begin
                t_reg    <= now_reg;
                fin_reg  <= retire_now;
                busy_reg <= 1'b0;
                run_reg  <= '0;
                if (retire_now)
                begin
                    retired_reg <= retired_reg + CNT_W'(1);
                    ready_reg[runner_reg] <= 1'b0;
                    run_v_reg <= 1'b0;
                    fin_slot_reg <= runner_reg;
                    if (retired_reg + CNT_W'(1) >= n_eff)
                        done_reg <= 1'b1;
                end
            end
            if (cmd.arrive_first || cmd.scan_first)
                idx_reg <= '0;
            else if (cmd.arrive_step || cmd.scan_step)
                idx_reg <= idx_reg + SLOT_W'(1);
            if (cmd.arrive_step)
            begin
                if (arr_mem[idx_reg] == now_reg)
                begin
                    ready_reg[idx_reg] <= 1'b1;
                    if (is_rr && count_reg < CNT_W'(SLOTS))
                        count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (cmd.purge_step)
            begin
                head_reg  <= head_reg + SLOT_W'(1);
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.scan_first)
                have_reg <= 1'b0;
            if (cmd.scan_step)
            begin
                if (ready_reg[idx_reg] && (!have_reg
                    || (is_sjf && rem_mem[idx_reg] < best_rem_reg)))
                begin
                    have_reg <= 1'b1;
                    best_reg <= idx_reg;
                    best_rem_reg <= rem_mem[idx_reg];
                end
            end
            if (cmd.commit)
            begin
                if (switch)
                begin
                    runner_reg <= pick;
                    run_v_reg  <= 1'b1;
                    if (is_rr)
                    begin
                        if (count_reg != '0)
                        begin
                            head_reg <= head_reg + SLOT_W'(1);
                            // pop then push: net count holds when a runner returns
                            if (!run_v_reg)
                                count_reg <= count_reg - CNT_W'(1);
                        end
                        else if (run_v_reg)
                            count_reg <= count_reg + CNT_W'(1);
                        slice_reg <= QUANTUM_W'(1);
                    end
                end
                else if (run_v_reg && is_rr && rr_clear_slice)
                    slice_reg <= QUANTUM_W'(1);
                else if (run_v_reg && is_rr && slice_reg != '1)
                    slice_reg <= slice_reg + QUANTUM_W'(1);
                else if (rr_clear_slice)
                    slice_reg <= '0;
                // the runner keeps the CPU even when the scan finds nothing
                busy_reg <= switch || run_v_reg;
                run_reg  <= switch ? pick : (run_v_reg ? runner_reg : '0);
                now_reg  <= now_reg + TIME_W'(1);
            end
            if (cmd.capture)
            begin
                res_busy     <= busy_reg;
                res_run      <= run_reg;
                res_fin      <= fin_reg;
                res_fin_slot <= fin_reg ? fin_slot_reg : '0;
                res_done     <= done_reg;
                res_time     <= t_reg;
            end
        end
    end
endmodule

// ===== rtl/tick_cpu_scheduler.sv =====
`timescale 1ns / 1ps
// Single-CPU tick scheduler (FIFO, round robin, SJF, preemptive SJF). A load
// transfer writes one slot's arrival and run length and gives no result. A
// tick transfer walks the slots in use once for arrivals, drains stale
// round-robin ring entries one per cycle, walks the slots again for the pick and
// commits, but once all processes are done it goes straight to the result; one
// result transfer follows. Registers are to be written through the cfg port only
// at an idle moment; the block itself does not enforce this.
module tick_cpu_scheduler
    import tcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcs_in_if.sink      in_ch,
    tcs_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data
);
    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;
    logic  out_v_reg;
    logic  out_free;

    // result register is free when empty or being taken
    assign out_free = !out_v_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (cmd.capture)
            out_v_reg <= 1'b1;
        else if (out_ch.ready)
            out_v_reg <= 1'b0;
    end

    assign in_ch.ready = in_ready;
    assign out_ch.valid = out_v_reg;

    tcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    tcs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_slot      (in_ch.slot),
        .in_arrival   (in_ch.arrival),
        .in_burst     (in_ch.burst),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .res_busy     (out_ch.cpu_busy),
        .res_run      (out_ch.running_slot),
        .res_fin      (out_ch.finished_valid),
        .res_fin_slot (out_ch.finished_slot),
        .res_done     (out_ch.all_done),
        .res_time     (out_ch.tick_time)
    );
endmodule
